FILE: design/hsvt_pkg.sv
// ----------------------------------------------------------------------------
// hsvt_pkg
// Shared types, constants and helpers of the RGB565 to HSV threshold core.
// ----------------------------------------------------------------------------
package hsvt_pkg;

	localparam int PIX_W  = 16;            // packed RGB565 pixel
	localparam int CH_W   = 8;             // widened channel, saturation, value
	localparam int HUE_W  = 9;             // hue in degrees, 0..359
	localparam int QUO_W  = 8;             // quotient bits of each divider lane
	localparam int DVD_W  = CH_W + QUO_W;  // dividend / accumulator width
	localparam int CIDX_W = 3;             // configuration index width
	localparam int CDAT_W = 9;             // configuration data width

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_HUE_MIN = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_HUE_MAX = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SAT_MIN = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_SAT_MAX = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_VAL_MIN = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_VAL_MAX = 3'd5;

	// Which channel holds the maximum.
	localparam logic [1:0] SEC_RED = 2'd0;
	localparam logic [1:0] SEC_GRN = 2'd1;
	localparam logic [1:0] SEC_BLU = 2'd2;

	localparam logic [7:0]       HUE_SCALE   = 8'd60;
	localparam logic [CH_W-1:0]  SAT_SCALE   = 8'd255;
	localparam logic signed [9:0] HUE_BASE_RED = 10'sd0;
	localparam logic signed [9:0] HUE_BASE_GRN = 10'sd120;
	localparam logic signed [9:0] HUE_BASE_BLU = 10'sd240;
	localparam logic signed [9:0] HUE_WRAP     = 10'sd360;

	// Reset values of the bounds.
	localparam logic [HUE_W-1:0] HUE_MIN_RST = 9'd0;
	localparam logic [HUE_W-1:0] HUE_MAX_RST = 9'd359;
	localparam logic [CH_W-1:0]  SV_MIN_RST  = 8'd0;
	localparam logic [CH_W-1:0]  SV_MAX_RST  = 8'd255;

	// One word inside the divider pipeline. Each accumulator starts as the
	// dividend and ends with the remainder on top and the quotient below.
	typedef struct packed {
		logic [DVD_W-1:0] hue_acc;
		logic             hue_neg;
		logic [CH_W-1:0]  delta;
		logic [DVD_W-1:0] sat_acc;
		logic [CH_W-1:0]  val;
		logic [1:0]       sector;
	} hsvt_div_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_min;
		logic [HUE_W-1:0] hue_max;
		logic [CH_W-1:0]  sat_min;
		logic [CH_W-1:0]  sat_max;
		logic [CH_W-1:0]  val_min;
		logic [CH_W-1:0]  val_max;
	} hsvt_bounds_t;

	function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [CH_W-1:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

endpackage

FILE: design/hsvt_front.sv
// ----------------------------------------------------------------------------
// hsvt_front
// Widens the pixel, finds max/min and sector, and forms both dividends.
// ----------------------------------------------------------------------------
module hsvt_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [hsvt_pkg::PIX_W-1:0] pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output hsvt_pkg::hsvt_div_t      out_data
);
	import hsvt_pkg::*;

	logic [CH_W-1:0] r, g, b, mx, mn;
	logic [1:0]      sector;
	logic signed [CH_W:0] diff;
	logic [CH_W-1:0] mag;

	logic            v_s1, v_s2;
	logic            rdy_s1, rdy_s2;
	logic [CH_W-1:0] mag_s1, delta_s1, val_s1;
	logic            neg_s1;
	logic [1:0]      sector_s1;
	hsvt_div_t       word_s2;

	assign r = widen5(pixel[15:11]);
	assign g = widen6(pixel[10:5]);
	assign b = widen5(pixel[4:0]);

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	// Red wins a tie for the maximum, then green.
	always_comb begin
		priority if (mx == r) sector = SEC_RED;
		else if (mx == g)     sector = SEC_GRN;
		else                  sector = SEC_BLU;
	end

	always_comb begin
		unique case (sector)
			SEC_RED: diff = $signed({1'b0, g}) - $signed({1'b0, b});
			SEC_GRN: diff = $signed({1'b0, b}) - $signed({1'b0, r});
			default: diff = $signed({1'b0, r}) - $signed({1'b0, g});
		endcase
		mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_s1    <= mag;
			neg_s1    <= diff[CH_W];
			delta_s1  <= mx - mn;
			val_s1    <= mx;
			sector_s1 <= sector;
		end
		if (rdy_s2 && v_s1) begin
			word_s2.hue_acc <= DVD_W'(mag_s1) * DVD_W'(HUE_SCALE);
			word_s2.hue_neg <= neg_s1;
			word_s2.delta   <= delta_s1;
			word_s2.sat_acc <= DVD_W'(delta_s1) * DVD_W'(SAT_SCALE);
			word_s2.val     <= val_s1;
			word_s2.sector  <= sector_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = word_s2;

endmodule

FILE: design/hsvt_div.sv
// ----------------------------------------------------------------------------
// hsvt_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module hsvt_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvt_pkg::hsvt_div_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvt_pkg::hsvt_div_t out_data
);
	import hsvt_pkg::*;

	// Both quotients are known to fit in QUO_W bits, so the top CH_W bits of
	// the dividend are already below the divisor and serve as the first
	// partial remainder.
	function automatic logic [DVD_W-1:0] lane_step(input logic [DVD_W-1:0] acc,
	                                                input logic [CH_W-1:0] d);
		logic [CH_W:0]   t;
		logic [CH_W:0]   rem;
		logic            q;
		t   = acc[DVD_W-1:QUO_W-1];
		q   = (t >= {1'b0, d});
		rem = q ? t - {1'b0, d} : t;
		return {rem[CH_W-1:0], acc[QUO_W-2:0], q};
	endfunction

	hsvt_div_t        div_s   [QUO_W];
	logic [QUO_W-1:0] div_v_s;
	logic [QUO_W:0]   rdy;

	assign rdy[QUO_W] = out_ready;
	assign in_ready   = rdy[0];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		hsvt_div_t src;
		hsvt_div_t nxt;
		logic      src_v;

		if (k == 0) begin : g_first
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = div_s[k-1];
			assign src_v = div_v_s[k-1];
		end

		assign rdy[k] = !div_v_s[k] || rdy[k+1];

		// The word passes through unchanged apart from one step of each lane.
		always_comb begin
			nxt         = src;
			nxt.hue_acc = lane_step(src.hue_acc, src.delta);
			nxt.sat_acc = lane_step(src.sat_acc, src.val);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				div_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				div_s[k] <= nxt;
			end
		end
	end

	assign out_valid = div_v_s[QUO_W-1];
	assign out_data  = div_s[QUO_W-1];

endmodule

FILE: design/hsvt_back.sv
// ----------------------------------------------------------------------------
// hsvt_back
// Assembles hue, cleans up gray and black cases, and checks the bounds.
// ----------------------------------------------------------------------------
module hsvt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hsvt_pkg::hsvt_div_t        in_data,
	input  hsvt_pkg::hsvt_bounds_t     bounds,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [hsvt_pkg::HUE_W-1:0] hue_deg,
	output logic [hsvt_pkg::CH_W-1:0]  saturation,
	output logic [hsvt_pkg::CH_W-1:0]  brightness,
	output logic                       in_range
);
	import hsvt_pkg::*;

	logic signed [9:0] base, qs, hsum;
	logic [HUE_W-1:0]  hue;
	logic              hue_ok, sat_ok, val_ok;

	logic              v_s11, v_s12, rdy_s11, rdy_s12;
	logic [HUE_W-1:0]  hue_s11, hue_s12;
	logic [CH_W-1:0]   sat_s11, sat_s12, val_s11, val_s12;
	logic              match_s12;

	always_comb begin
		unique case (in_data.sector)
			SEC_RED: base = HUE_BASE_RED;
			SEC_GRN: base = HUE_BASE_GRN;
			default: base = HUE_BASE_BLU;
		endcase
		qs   = $signed({2'b00, in_data.hue_acc[QUO_W-1:0]});
		hsum = in_data.hue_neg ? base - qs : base + qs;
		if (hsum < 0) hsum = hsum + HUE_WRAP;
		hue  = (in_data.delta == '0) ? '0 : hsum[HUE_W-1:0];
	end

	// A wrapped hue window matches at either end.
	always_comb begin
		if (bounds.hue_min <= bounds.hue_max)
			hue_ok = (hue_s11 >= bounds.hue_min) && (hue_s11 <= bounds.hue_max);
		else
			hue_ok = (hue_s11 >= bounds.hue_min) || (hue_s11 <= bounds.hue_max);
		sat_ok = (sat_s11 >= bounds.sat_min) && (sat_s11 <= bounds.sat_max);
		val_ok = (val_s11 >= bounds.val_min) && (val_s11 <= bounds.val_max);
	end

	assign rdy_s12  = !v_s12 || out_ready;
	assign rdy_s11  = !v_s11 || rdy_s12;
	assign in_ready = rdy_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (rdy_s11) v_s11 <= in_valid;
			if (rdy_s12) v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s11 && in_valid) begin
			hue_s11 <= hue;
			sat_s11 <= (in_data.val == '0) ? '0 : in_data.sat_acc[QUO_W-1:0];
			val_s11 <= in_data.val;
		end
		if (rdy_s12 && v_s11) begin
			hue_s12   <= hue_s11;
			sat_s12   <= sat_s11;
			val_s12   <= val_s11;
			match_s12 <= hue_ok && sat_ok && val_ok;
		end
	end

	assign out_valid  = v_s12;
	assign hue_deg    = hue_s12;
	assign saturation = sat_s12;
	assign brightness = val_s12;
	assign in_range   = match_s12;

endmodule

FILE: design/rgb565_hsv_color_threshold_core.sv
// ----------------------------------------------------------------------------
// rgb565_hsv_color_threshold_core
// RGB565 to HSV conversion with an inclusive HSV window match flag.
// ----------------------------------------------------------------------------
// Pixels arrive as 16-bit RGB565 words on the s_axis stream. Each word yields
// one result word on m_axis: hue in degrees (0..359), saturation and
// brightness (0..255) in tdata, and the window match flag in tuser.
// The six bounds are written over the cfg channel, which is always ready;
// index 0..5 selects hue_min, hue_max, sat_min, sat_max, val_min, val_max and
// other indexes are dropped. Bounds should be written while no pixel is in
// flight. A hue window whose minimum exceeds its maximum wraps through zero.
// The datapath is a twelve-stage pipeline: two front stages widen the pixel
// and form the dividends, eight stages each resolve one quotient bit of the
// hue and saturation divisions side by side, and two back stages assemble
// hue and compare it against the window. Every stage is registered, and one
// word per cycle goes through while m_axis is not stalled.
// Every stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver only holds back the unbroken run of full stages at the end;
// gaps in the pipeline still fill while m_axis waits. Nothing is dropped or
// repeated. Reset clears all stage valid flags and restores default bounds.
// ----------------------------------------------------------------------------
module rgb565_hsv_color_threshold_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Pixel stream. tdata: pixel_rgb565[15:0].
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,
	// Result stream. tdata: hue_deg[8:0], saturation[16:9], brightness[24:17],
	// zeros[31:25]. tuser: in_range[0].
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,
	output logic                        m_axis_tuser,
	// Configuration writes.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hsvt_pkg::CIDX_W-1:0] cfg_index,
	input  logic [hsvt_pkg::CDAT_W-1:0] cfg_data
);
	import hsvt_pkg::*;

	hsvt_bounds_t     bounds_q;
	logic             fr_valid, fr_ready, dv_valid, dv_ready;
	hsvt_div_t        fr_data, dv_data;
	logic [HUE_W-1:0] hue_deg;
	logic [CH_W-1:0]  saturation, brightness;

	assign cfg_ready = 1'b1;

	// Bound registers; hue bounds keep all nine bits, the others the low byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q.hue_min <= HUE_MIN_RST;
			bounds_q.hue_max <= HUE_MAX_RST;
			bounds_q.sat_min <= SV_MIN_RST;
			bounds_q.sat_max <= SV_MAX_RST;
			bounds_q.val_min <= SV_MIN_RST;
			bounds_q.val_max <= SV_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HUE_MIN: bounds_q.hue_min <= cfg_data;
				CFG_HUE_MAX: bounds_q.hue_max <= cfg_data;
				CFG_SAT_MIN: bounds_q.sat_min <= cfg_data[CH_W-1:0];
				CFG_SAT_MAX: bounds_q.sat_max <= cfg_data[CH_W-1:0];
				CFG_VAL_MIN: bounds_q.val_min <= cfg_data[CH_W-1:0];
				CFG_VAL_MAX: bounds_q.val_max <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	hsvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pixel     (s_axis_tdata),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_data  (fr_data)
	);

	hsvt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_data  (dv_data)
	);

	hsvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (dv_valid),
		.in_ready   (dv_ready),
		.in_data    (dv_data),
		.bounds     (bounds_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hue_deg    (hue_deg),
		.saturation (saturation),
		.brightness (brightness),
		.in_range   (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, brightness, saturation, hue_deg};

endmodule

FILE: design/hsvt_checker.sv
// ----------------------------------------------------------------------------
// hsvt_checker
// Port-level checks of the RGB565 to HSV threshold core, bound to the top.
// ----------------------------------------------------------------------------
module hsvt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A held result word keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// Hue never reaches a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd359)
		else $error("hue out of range");

	// Zero saturation means a gray pixel, whose hue is zero.
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16:9] == 8'd0 |-> m_axis_tdata[8:0] == 9'd0)
		else $error("gray pixel with nonzero hue");

	// Black, with zero brightness, gives zero saturation.
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24:17] == 8'd0 |-> m_axis_tdata[16:9] == 8'd0)
		else $error("black pixel with nonzero saturation");

	// The input only backs up behind a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with no waiting result");

endmodule

bind rgb565_hsv_color_threshold_core hsvt_checker u_hsvt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB565 to HSV color threshold core.
// ----------------------------------------------------------------------------
// Pixel words go in on s_axis. Every accepted pixel gets its hue, saturation,
// brightness and window flag computed by a predictor in this file. Result
// words from m_axis are checked field by field against the oldest prediction.
// A short table of hand-picked pixels runs first under the reset window.
// Then several phases follow, each with its own HSV window and its own mix of
// sender gaps and receiver stalls, two of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsvt_pkg::*;

	// Twelve pipeline stages between the pixel and its result word.
	localparam int PIPE_LATENCY = 12;
	// Receiver hold-off long enough to fill the pipeline and stall the input.
	localparam int HOLD_OFF_CYCLES = 80;

	// Spare register indexes; the core must drop writes to them.
	localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// One result word as the core should deliver it.
	typedef struct packed {
		logic [HUE_W-1:0] hue_deg;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  brightness;
		logic             in_range;
	} hsv_word_t;

	// A row of the directed table. When known is set, the expected word is
	// typed in by hand; otherwise the predictor supplies it.
	typedef struct {
		logic [PIX_W-1:0] pixel;
		bit               known;
		hsv_word_t        want;
	} pixel_row_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// One phase of the random part: window, idling, pixel count, hold-off.
	typedef struct {
		hsvt_bounds_t window;
		idle_mode_t   idling;
		int           pixels;
		bit           hold_off;
		bit           random_window;
	} phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PIX_W-1:0]    s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;
	logic                m_axis_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [CDAT_W-1:0]   cfg_data = '0;

	// Mirror of the bound registers inside the core.
	hsvt_bounds_t window_regs;
	// Predicted result words, oldest first.
	hsv_word_t    expected_hsv_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	int mismatch_count  = 0;
	int pixels_sent     = 0;
	int results_checked = 0;
	int matches_seen    = 0;
	int reg_writes      = 0;

	// The first nine rows have their answers read straight off the formulas:
	// black, white, the three primaries, the three two-way ties of the
	// maximum (red wins over green and blue, green over blue) and a gray.
	pixel_row_t directed_rows [0:19] = '{
		'{16'h0000, 1'b1, '{9'd0,   8'd0,   8'd0,   1'b1}},
		'{16'hFFFF, 1'b1, '{9'd0,   8'd0,   8'd255, 1'b1}},
		'{16'hF800, 1'b1, '{9'd0,   8'd255, 8'd255, 1'b1}},
		'{16'h07E0, 1'b1, '{9'd120, 8'd255, 8'd255, 1'b1}},
		'{16'h001F, 1'b1, '{9'd240, 8'd255, 8'd255, 1'b1}},
		'{16'hFFE0, 1'b1, '{9'd60,  8'd255, 8'd255, 1'b1}},
		'{16'h07FF, 1'b1, '{9'd180, 8'd255, 8'd255, 1'b1}},
		'{16'hF81F, 1'b1, '{9'd300, 8'd255, 8'd255, 1'b1}},
		'{16'hE73C, 1'b1, '{9'd0,   8'd0,   8'd231, 1'b1}},
		// Red maximum with blue just above green: the negative quotient
		// truncates toward zero and wraps to 359.
		'{16'hF801, 1'b0, '0},
		'{16'h0001, 1'b0, '0},
		'{16'h0020, 1'b0, '0},
		'{16'h0800, 1'b0, '0},
		'{16'h8410, 1'b0, '0},
		'{16'h7BEF, 1'b0, '0},
		'{16'hF81E, 1'b0, '0},
		'{16'h07C1, 1'b0, '0},
		'{16'hAAAA, 1'b0, '0},
		'{16'h5555, 1'b0, '0},
		// Darkest gray: all three channels widen to 8.
		'{16'h0841, 1'b0, '0}
	};

	// Windows of the random part. They cover a hue window that wraps through
	// zero, an inverted saturation window, hue bounds above 359, a window that
	// wraps at its very ends, a window of a single black point and the full
	// window written back explicitly.
	phase_t phases [0:6] = '{
		'{'{9'd300, 9'd60,  8'd64,  8'd255, 8'd32,  8'd255}, IDLE_NONE,     70, 1'b1, 1'b0},
		'{'{9'd100, 9'd200, 8'd200, 8'd100, 8'd0,   8'd255}, IDLE_SENDER,   55, 1'b0, 1'b0},
		'{'{9'd0,   9'd511, 8'd0,   8'd255, 8'd255, 8'd255}, IDLE_RECEIVER, 55, 1'b0, 1'b0},
		'{'{9'd359, 9'd0,   8'd0,   8'd255, 8'd0,   8'd128}, IDLE_BOTH,     55, 1'b0, 1'b0},
		'{'{9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   8'd0},   IDLE_BOTH,     60, 1'b0, 1'b1},
		'{'{9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   8'd0},   IDLE_SENDER,   55, 1'b0, 1'b0},
		'{'{9'd0,   9'd359, 8'd0,   8'd255, 8'd0,   8'd255}, IDLE_RECEIVER, 50, 1'b1, 1'b0}
	};

	rgb565_hsv_color_threshold_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Hue, saturation, brightness and window flag of one pixel. Channels are
	// widened by copying their top bits below them. The hue quotient is
	// signed and truncates toward zero, as SystemVerilog division on int does.
	function automatic hsv_word_t predict_hsv(input logic [PIX_W-1:0] px,
			input hsvt_bounds_t win);
		hsv_word_t res;
		int  red, grn, blu, top, bottom, delta, num, base, hue, sat;
		bit  hue_ok;
		red = int'({px[15:11], px[15:13]});
		grn = int'({px[10:5], px[10:9]});
		blu = int'({px[4:0], px[4:2]});
		top = red;
		bottom = red;
		if (grn > top) top = grn;
		if (blu > top) top = blu;
		if (grn < bottom) bottom = grn;
		if (blu < bottom) bottom = blu;
		delta = top - bottom;
		hue = 0;
		if (delta != 0) begin
			if (top == red) begin
				base = 0;
				num = 60 * (grn - blu);
			end else if (top == grn) begin
				base = 120;
				num = 60 * (blu - red);
			end else begin
				base = 240;
				num = 60 * (red - grn);
			end
			hue = base + num / delta;
			if (hue < 0) hue += 360;
			if (hue >= 360) hue -= 360;
		end
		sat = (top != 0) ? (delta * 255) / top : 0;
		// The hue window wraps through zero when its minimum is the larger.
		if (win.hue_min <= win.hue_max)
			hue_ok = hue >= int'(win.hue_min) && hue <= int'(win.hue_max);
		else
			hue_ok = hue >= int'(win.hue_min) || hue <= int'(win.hue_max);
		res.hue_deg    = HUE_W'(hue);
		res.saturation = CH_W'(sat);
		res.brightness = CH_W'(top);
		res.in_range   = hue_ok && sat >= int'(win.sat_min) && sat <= int'(win.sat_max)
			&& top >= int'(win.val_min) && top <= int'(win.val_max);
		return res;
	endfunction

	// Random pixel, mostly uniform, with a share of grays, near grays, tied
	// maxima and channels pinned to zero or full scale.
	function automatic logic [PIX_W-1:0] random_pixel();
		logic [4:0] r5, b5;
		logic [5:0] g6;
		r5 = 5'($urandom_range(0, 31));
		g6 = 6'($urandom_range(0, 63));
		b5 = 5'($urandom_range(0, 31));
		case ($urandom_range(0, 11))
			6: begin
				g6 = {r5, 1'($urandom_range(0, 1))};
				b5 = r5 ^ 5'($urandom_range(0, 1));
			end
			7: begin
				b5 = r5;
			end
			8: begin
				g6 = {r5, r5[4]};
			end
			9: begin
				g6 = {b5, b5[4]};
			end
			10: begin
				r5 = {5{r5[0]}};
				g6 = {6{g6[0]}};
				b5 = {5{b5[0]}};
			end
			default: ;
		endcase
		return {r5, g6, b5};
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("MISMATCH at result %0d, %s: got %0d, expected %0d",
			results_checked, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_result();
		hsv_word_t want;
		results_checked++;
		if (expected_hsv_q.size() == 0) begin
			report_mismatch("word with nothing expected", int'(m_axis_tdata[24:0]), 0);
			return;
		end
		want = expected_hsv_q.pop_front();
		if (m_axis_tdata[8:0] !== want.hue_deg)
			report_mismatch("hue_deg", int'(m_axis_tdata[8:0]), int'(want.hue_deg));
		if (m_axis_tdata[16:9] !== want.saturation)
			report_mismatch("saturation", int'(m_axis_tdata[16:9]), int'(want.saturation));
		if (m_axis_tdata[24:17] !== want.brightness)
			report_mismatch("brightness", int'(m_axis_tdata[24:17]), int'(want.brightness));
		if (m_axis_tdata[31:25] !== '0)
			report_mismatch("tdata padding", int'(m_axis_tdata[31:25]), 0);
		if (m_axis_tuser !== want.in_range)
			report_mismatch("in_range", int'(m_axis_tuser), int'(want.in_range));
		if (want.in_range) matches_seen++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 66;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 66;
			end
			default: begin
				send_idle_pct = 33;
				recv_stall_pct = 33;
			end
		endcase
	endtask

	// Offers one pixel, after a random number of idle cycles, and records its
	// expected result word once the core takes it. tvalid is left high so the
	// next pixel can follow in the very next cycle.
	task automatic send_pixel(input logic [PIX_W-1:0] px, input bit known,
			input hsv_word_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_hsv_q.push_back(known ? want : predict_hsv(px, window_regs));
		pixels_sent++;
	endtask

	// One register write; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_HUE_MIN: window_regs.hue_min = data;
			CFG_HUE_MAX: window_regs.hue_max = data;
			CFG_SAT_MIN: window_regs.sat_min = data[CH_W-1:0];
			CFG_SAT_MAX: window_regs.sat_max = data[CH_W-1:0];
			CFG_VAL_MIN: window_regs.val_min = data[CH_W-1:0];
			CFG_VAL_MAX: window_regs.val_max = data[CH_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Writes a whole window. The eight-bit bounds get a random top bit in the
	// data word, which the core has to drop. The two spare indexes get random
	// data too, and the window must not change because of them.
	task automatic write_window(input hsvt_bounds_t win);
		write_reg(CFG_HUE_MIN, win.hue_min);
		write_reg(CFG_SAT_MIN, {1'($urandom_range(0, 1)), win.sat_min});
		write_reg(CFG_SPARE_LO, CDAT_W'($urandom_range(0, 511)));
		write_reg(CFG_HUE_MAX, win.hue_max);
		write_reg(CFG_SAT_MAX, {1'($urandom_range(0, 1)), win.sat_max});
		write_reg(CFG_VAL_MIN, {1'($urandom_range(0, 1)), win.val_min});
		write_reg(CFG_SPARE_HI, CDAT_W'($urandom_range(0, 511)));
		write_reg(CFG_VAL_MAX, {1'($urandom_range(0, 1)), win.val_max});
		cfg_valid <= 1'b0;
	endtask

	// Waits until every pixel sent so far has come back.
	task automatic wait_all_returned();
		while (expected_hsv_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: checks a word at each handshake and then picks tready for the
	// next cycle, either held low by a pending hold-off or at random.
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) check_result();
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Main sequence: reset, directed table, then the random phases.
	initial begin
		hsvt_bounds_t win;
		window_regs = '{HUE_MIN_RST, HUE_MAX_RST, SV_MIN_RST, SV_MAX_RST,
			SV_MIN_RST, SV_MAX_RST};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels under the reset window, back to back.
		set_idling(IDLE_NONE);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pixel, directed_rows[i].known, directed_rows[i].want);
		s_axis_tvalid <= 1'b0;
		wait_all_returned();

		foreach (phases[p]) begin
			win = phases[p].window;
			if (phases[p].random_window) begin
				win.hue_min = HUE_W'($urandom_range(0, 511));
				win.hue_max = HUE_W'($urandom_range(0, 511));
				win.sat_min = CH_W'($urandom_range(0, 127));
				win.sat_max = CH_W'($urandom_range(64, 255));
				win.val_min = CH_W'($urandom_range(0, 127));
				win.val_max = CH_W'($urandom_range(64, 255));
			end
			// The core is idle here: every earlier result has been taken.
			write_window(win);
			set_idling(phases[p].idling);
			// The hold-off keeps the receiver away while the sender keeps
			// offering, so the pipeline fills and pushes back on s_axis.
			if (phases[p].hold_off) hold_left = HOLD_OFF_CYCLES;
			repeat (phases[p].pixels) send_pixel(random_pixel(), 1'b0, '0);
			s_axis_tvalid <= 1'b0;
			wait_all_returned();
		end

		// Wait on past the last result to catch any stray extra word.
		repeat (2 * PIPE_LATENCY + 4) @(posedge clk);
		$display("Covered %0d pixels and %0d result words, %0d of them inside the window.",
			pixels_sent, results_checked, matches_seen);
		$display("Made %0d register writes over %0d windows, with %0d mismatches.",
			reg_writes, $size(phases), mismatch_count);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: ends a run that hangs.
	initial begin
		#2_000_000;
		$display("TIMEOUT with %0d result words still expected", expected_hsv_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
